// ===== sv/prrs_pkg.sv =====
// Package for the priority round-robin scheduler.
// Holds sizes, codes, control structs and small helper functions.
// No dependencies.
package prrs_pkg;

  localparam int NUM_LEVELS  = 32;
  localparam int NUM_THREADS = 64;

  localparam int KindW = 3;
  localparam int IdW   = 6;
  localparam int PrioW = 5;
  localparam int StatW = 2;

  localparam int LvlW = $clog2(NUM_LEVELS);
  localparam int TidW = $clog2(NUM_THREADS);
  localparam int CntW = $clog2(NUM_THREADS + 1);

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_CHANGE = 3'd2,
    KIND_SELECT = 3'd3,
    KIND_TERM   = 3'd4
  } kind_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_IDLE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic push;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic need_push;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic            found;
    logic [LvlW-1:0] lvl;
  } lvl_t;

  // Priority encoder: highest set bit of the level map.
  function automatic lvl_t find_top(logic [NUM_LEVELS-1:0] m);
    lvl_t r;
    r = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (m[i]) begin
        r.found = 1'b1;
        r.lvl   = LvlW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [LvlW-1:0] clamp_level(logic [PrioW-1:0] p);
    if (32'(p) >= 32'(NUM_LEVELS)) return LvlW'(NUM_LEVELS - 1);
    return LvlW'(p);
  endfunction

endpackage

// ===== sv/prrs_if.sv =====
// Channel interfaces of the scheduler: event input, result output, config write.
// Depends on prrs_pkg.
interface prrs_in_if import prrs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [IdW-1:0]   thread_id;
  logic [PrioW-1:0] priority_req;
  logic [PrioW-1:0] old_priority;
  modport source(output valid, kind, thread_id, priority_req, old_priority, input ready);
  modport sink(input valid, kind, thread_id, priority_req, old_priority, output ready);
endinterface

interface prrs_out_if import prrs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IdW-1:0]   run_thread;
  logic [PrioW-1:0] current_level;
  logic             switched;
  logic             timer_enable;
  logic [StatW-1:0] status;
  modport source(output valid, run_thread, current_level, switched, timer_enable, status,
                 input ready);
  modport sink(input valid, run_thread, current_level, switched, timer_enable, status,
               output ready);
endinterface

interface prrs_cfg_if import prrs_pkg::*;;
  logic           valid;
  logic           ready;
  logic [IdW-1:0] idle_id;
  modport source(output valid, idle_id, input ready);
  modport sink(input valid, idle_id, output ready);
endinterface

// ===== sv/priority_round_robin_scheduler.sv =====
// Priority round-robin scheduler: one FIFO ready queue per level, head rotation on select.
// Each accepted item passes the execute state, then, for an accepted change of priority,
// an insert state after any unlink, then the result load, which waits while the output
// register holds a result not yet taken. Items are handled one at a time; the next item
// is taken while the result waits in the output register.
// Reset: queues empty, no running thread, idle thread 0; no clearing pass is needed.
module priority_round_robin_scheduler import prrs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  prrs_in_if.sink    in_i,
  prrs_out_if.source out_o,
  prrs_cfg_if.sink   cfg_i
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  prrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .stat_i(stat),
    .cmd_o(cmd)
  );

  prrs_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .kind_i(in_i.kind),
    .thread_id_i(in_i.thread_id),
    .priority_req_i(in_i.priority_req),
    .old_priority_i(in_i.old_priority),
    .cfg_we_i(cfg_i.valid),
    .cfg_idle_i(cfg_i.idle_id),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .current_thread_o(out_o.run_thread),
    .current_level_o(out_o.current_level),
    .switched_o(out_o.switched),
    .timer_enable_o(out_o.timer_enable),
    .status_o(out_o.status)
  );
endmodule

// ===== sv/prrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/prrs_ctrl.sv =====
// Sequencer of the scheduler: steps each item through execute, optional
// second insert step and result load. Depends on prrs_pkg.
module prrs_ctrl import prrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_push ? ST_PUSH : ST_FIN;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/prrs_dp.sv =====
// Datapath of the scheduler: ready-queue head/tail/count registers, link
// memories, level map, running thread and result register. Depends on prrs_pkg, prrs_ram.
module prrs_dp import prrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_stat_t         stat_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [IdW-1:0]   thread_id_i,
  input  logic [PrioW-1:0] priority_req_i,
  input  logic [PrioW-1:0] old_priority_i,
  input  logic             cfg_we_i,
  input  logic [IdW-1:0]   cfg_idle_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdW-1:0]   current_thread_o,
  output logic [PrioW-1:0] current_level_o,
  output logic             switched_o,
  output logic             timer_enable_o,
  output logic [StatW-1:0] status_o
);
  // Captured item.
  kind_e           kind_q;
  logic [IdW-1:0]  tid_q;
  logic [TidW-1:0] t_q;
  logic            tidok_q;
  logic [LvlW-1:0] lvl_q, olvl_q;
  lvl_t            bef_q;

  // Queue state.
  logic [TidW-1:0]        head_q [NUM_LEVELS];
  logic [TidW-1:0]        tail_q [NUM_LEVELS];
  logic [CntW-1:0]        cnt_q  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0]  map_q;
  logic [NUM_THREADS-1:0] mark_q;
  logic [IdW-1:0]         run_q, idle_q;
  logic                   run_vld_q, reeval_q, pushed_q;

  // Per-item results.
  logic    sw_q, timer_q;
  status_e status_q;

  logic             out_vld_q, out_sw_q, out_timer_q;
  logic [IdW-1:0]   out_thread_q;
  logic [PrioW-1:0] out_level_q;
  logic [StatW-1:0] out_status_q;

  // Link memory read data.
  logic [TidW-1:0] rd_next, rd_prev;
  logic [LvlW-1:0] rd_lvl;

  lvl_t            top;
  logic [LvlW-1:0] op_lvl;
  logic [TidW-1:0] head_r, tail_r, t_in, raddr;
  logic [CntW-1:0] cnt_r;
  logic            mark_t, ok_add, ok_rem, ok_chg;
  logic            do_push, do_unlink, do_rot, ul_mid;
  logic            nx_we, pv_we;
  logic [TidW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
  logic [IdW-1:0]  chosen;

  assign top = find_top(map_q);

  // All level-indexed reads in a cycle share one index.
  always_comb begin
    priority if (cmd_i.load) begin
      op_lvl = top.lvl;
    end else if (cmd_i.push) begin
      op_lvl = lvl_q;
    end else if (cmd_i.fin) begin
      op_lvl = bef_q.lvl;
    end else if (kind_q == KIND_CHANGE) begin
      op_lvl = olvl_q;
    end else if (kind_q == KIND_SELECT) begin
      op_lvl = bef_q.lvl;
    end else begin
      op_lvl = lvl_q;
    end
  end

  assign head_r = head_q[op_lvl];
  assign tail_r = tail_q[op_lvl];
  assign cnt_r  = cnt_q[op_lvl];

  assign t_in  = TidW'(thread_id_i);
  assign raddr = (kind_e'(kind_i) == KIND_SELECT) ? head_r : t_in;

  assign mark_t = mark_q[t_q];
  assign ok_add = tidok_q && !mark_t;
  assign ok_rem = tidok_q && mark_t && (rd_lvl == lvl_q);
  assign ok_chg = tidok_q && (!mark_t || (rd_lvl == olvl_q));

  assign do_push   = (cmd_i.exec && kind_q == KIND_ADD && ok_add) || cmd_i.push;
  assign do_unlink = cmd_i.exec && ((kind_q == KIND_REMOVE && ok_rem) ||
                                    (kind_q == KIND_CHANGE && ok_chg && mark_t));
  assign do_rot    = cmd_i.exec && kind_q == KIND_SELECT && bef_q.found &&
                     (cnt_r > CntW'(1));
  // Removal from the middle of a queue touches both neighbors.
  assign ul_mid    = (cnt_r > CntW'(1)) && (head_r != t_q) && (tail_r != t_q);

  assign stat_o.need_push = (kind_q == KIND_CHANGE) && ok_chg;
  assign stat_o.out_free  = !out_vld_q || out_ready_i;

  assign chosen = bef_q.found ? IdW'(head_r) : idle_q;

  always_comb begin
    nx_we = 1'b0;
    nx_wa = tail_r;
    nx_wd = t_q;
    pv_we = 1'b0;
    pv_wa = t_q;
    pv_wd = tail_r;
    if (do_push && cnt_r != '0) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else if (do_unlink && ul_mid) begin
      nx_we = 1'b1;
      nx_wa = rd_prev;
      nx_wd = rd_next;
      pv_we = 1'b1;
      pv_wa = rd_next;
      pv_wd = rd_prev;
    end else if (do_rot) begin
      nx_we = 1'b1;
      nx_wd = head_r;
      pv_we = 1'b1;
      pv_wa = head_r;
    end
  end

  prrs_ram #(.Width(TidW), .Depth(NUM_THREADS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .re_i(cmd_i.load), .raddr_i(raddr), .rdata_o(rd_next)
  );

  prrs_ram #(.Width(TidW), .Depth(NUM_THREADS)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .re_i(cmd_i.load), .raddr_i(raddr), .rdata_o(rd_prev)
  );

  prrs_ram #(.Width(LvlW), .Depth(NUM_THREADS)) u_level (
    .clk_i, .we_i(do_push), .waddr_i(t_q), .wdata_i(lvl_q),
    .re_i(cmd_i.load), .raddr_i(t_in), .rdata_o(rd_lvl)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) cnt_q[i] <= '0;
      map_q     <= '0;
      mark_q    <= '0;
      run_q     <= '0;
      run_vld_q <= 1'b0;
      reeval_q  <= 1'b0;
      idle_q    <= '0;
      pushed_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) idle_q <= cfg_idle_i;
      if (cmd_i.load) pushed_q <= 1'b0;
      if (cmd_i.push) pushed_q <= 1'b1;
      if (do_push) begin
        cnt_q[op_lvl]  <= cnt_r + CntW'(1);
        map_q[op_lvl]  <= 1'b1;
        mark_q[t_q]    <= 1'b1;
      end else if (do_unlink) begin
        if (cnt_r != '0) cnt_q[op_lvl] <= cnt_r - CntW'(1);
        if (cnt_r <= CntW'(1)) map_q[op_lvl] <= 1'b0;
        mark_q[t_q] <= 1'b0;
      end
      if (cmd_i.exec) begin
        unique case (kind_q)
          KIND_ADD: begin
            if (ok_add && lvl_q > (bef_q.found ? bef_q.lvl : '0)) reeval_q <= 1'b1;
          end
          KIND_REMOVE: begin
            if (ok_rem) reeval_q <= 1'b1;
          end
          KIND_CHANGE: begin
            if (ok_chg && lvl_q > olvl_q) reeval_q <= 1'b1;
          end
          KIND_SELECT: begin
            reeval_q  <= 1'b0;
            run_q     <= chosen;
            run_vld_q <= 1'b1;
          end
          KIND_TERM: begin
            if (run_vld_q && run_q == tid_q) run_vld_q <= 1'b0;
          end
          default: ;
        endcase
      end
      // A move that empties the level that was highest forces a re-evaluation.
      if (cmd_i.fin && pushed_q && bef_q.found && cnt_r == '0) reeval_q <= 1'b1;
      if (cmd_i.fin) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_e'(kind_i);
      tid_q   <= thread_id_i;
      tidok_q <= 32'(thread_id_i) < 32'(NUM_THREADS);
      t_q     <= (32'(thread_id_i) < 32'(NUM_THREADS)) ? t_in : '0;
      lvl_q   <= clamp_level(priority_req_i);
      olvl_q  <= clamp_level(old_priority_i);
      bef_q   <= top;
    end
    if (do_push) begin
      if (cnt_r == '0) head_q[op_lvl] <= t_q;
      tail_q[op_lvl] <= t_q;
    end else if (do_unlink && cnt_r > CntW'(1)) begin
      if (head_r == t_q) begin
        head_q[op_lvl] <= rd_next;
      end else if (tail_r == t_q) begin
        tail_q[op_lvl] <= rd_prev;
      end
    end else if (do_rot) begin
      head_q[op_lvl] <= rd_next;
      tail_q[op_lvl] <= head_r;
    end
    if (cmd_i.exec) begin
      sw_q    <= (kind_q == KIND_SELECT) && (!run_vld_q || run_q != chosen || reeval_q);
      timer_q <= (kind_q == KIND_SELECT) && bef_q.found && (cnt_r > CntW'(1));
      unique case (kind_q)
        KIND_ADD:    status_q <= ok_add ? STAT_DONE : STAT_IGNORED;
        KIND_REMOVE: status_q <= ok_rem ? STAT_DONE : STAT_IGNORED;
        KIND_CHANGE: status_q <= ok_chg ? STAT_DONE : STAT_IGNORED;
        KIND_SELECT: status_q <= bef_q.found ? STAT_DONE : STAT_IDLE;
        KIND_TERM:   status_q <= STAT_DONE;
        default:     status_q <= STAT_IGNORED;
      endcase
    end
    if (cmd_i.fin) begin
      out_thread_q <= run_vld_q ? run_q : idle_q;
      out_level_q  <= PrioW'(top.lvl);
      out_sw_q     <= sw_q;
      out_timer_q  <= timer_q;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign current_thread_o = out_thread_q;
  assign current_level_o  = out_level_q;
  assign switched_o       = out_sw_q;
  assign timer_enable_o   = out_timer_q;
  assign status_o         = out_status_q;
endmodule

// ===== sv/prrs_checker.sv =====
// Port-level checks of the scheduler and the bind that attaches them.
// Depends on prrs_pkg and priority_round_robin_scheduler.
module prrs_checker import prrs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IdW-1:0]   out_thread_i,
  input logic [PrioW-1:0] out_level_i,
  input logic             out_switched_i,
  input logic             out_timer_i,
  input logic [StatW-1:0] out_status_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_thread_i) &&
                                    $stable(out_status_i))
    else $error("result changed while stalled");

  // Each item is worked on alone, so input is closed right after acceptance.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted while one is in work");

  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_IGNORED |-> !out_switched_i && !out_timer_i)
    else $error("ignored item reports a switch or timer");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_IDLE |-> out_level_i == '0 && !out_timer_i)
    else $error("idle chosen while queues hold threads");

  a_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_timer_i |-> out_status_i == STAT_DONE)
    else $error("timer enabled without a chosen queue");
endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_i.valid),
  .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_thread_i(out_o.run_thread),
  .out_level_i(out_o.current_level),
  .out_switched_i(out_o.switched),
  .out_timer_i(out_o.timer_enable),
  .out_status_i(out_o.status)
);
